@@ hdl/tdmass_pkg.sv @@
// ----------------------------------------------------------------------------
// TDMA slave sync package
// Shared codes, constants and payload types of the TDMA slave slot controller.
// ----------------------------------------------------------------------------
package tdmass_pkg;

    // Default width of the internal time arithmetic
    localparam int TIME_BITS_DEF = 48;
    // Width of every time field on the ports
    localparam int FIELD_TIME_W  = 48;

    // Saturation of the slot position: +-2^32 ms
    localparam int SLOT_SAT_LOG2 = 32;
    localparam int SLOT_W        = SLOT_SAT_LOG2 + 2;
    localparam int REM_W         = SLOT_W + 2;

    // Event commands
    localparam logic [2:0] CMD_PKT_RX     = 3'd1;
    localparam logic [2:0] CMD_RX_TIMEOUT = 3'd2;
    localparam logic [2:0] CMD_TX_DONE    = 3'd3;
    localparam logic [2:0] CMD_TX_FAIL    = 3'd4;

    // Packet kinds
    localparam logic [2:0] KIND_SYNC      = 3'd0;
    localparam logic [2:0] KIND_ACCEPT    = 3'd2;
    localparam logic [2:0] KIND_COMMAND   = 3'd3;

    // Link phases
    localparam logic [1:0] PH_DISC        = 2'd0;
    localparam logic [1:0] PH_CONNECTING  = 2'd1;
    localparam logic [1:0] PH_TX          = 2'd2;
    localparam logic [1:0] PH_RX          = 2'd3;

    // Radio actions
    localparam logic [1:0] ACT_NONE         = 2'd0;
    localparam logic [1:0] ACT_LISTEN       = 2'd1;
    localparam logic [1:0] ACT_SEND_CONNECT = 2'd2;
    localparam logic [1:0] ACT_SEND_DATA    = 2'd3;

    localparam logic [15:0] IDLE_LISTEN_MS  = 16'd2000;
    localparam logic [15:0] BUDGET_MAX      = 16'hFFFF;
    localparam logic [7:0]  MISS_MAX        = 8'd255;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MASTER_NODE_ID = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT_THR      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AIRTIME        = 8'd3;

    localparam logic [7:0]  MISS_LIMIT_RST = 8'd3;
    localparam logic [15:0] DRIFT_THR_RST  = 16'd10;
    localparam logic [15:0] AIRTIME_RST    = 16'd100;

    typedef struct packed {
        logic [2:0]              command;
        logic [FIELD_TIME_W-1:0] event_time_ms;
        logic [2:0]              pkt_kind;
        logic [7:0]              pkt_source;
        logic [FIELD_TIME_W-1:0] pkt_sent_time;
        logic [15:0]             pkt_period_ms;
        logic [15:0]             pkt_master_slot_ms;
        logic [15:0]             pkt_guard_ms;
        logic                    pkt_linked;
        logic [FIELD_TIME_W-1:0] pkt_connect_seen_time;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                     link_state;
        logic [1:0]                     radio_action;
        logic [15:0]                    action_timeout_ms;
        logic                           command_arrived;
        logic signed [FIELD_TIME_W-1:0] clock_offset_ms;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  master_node_id;
        logic [7:0]  miss_limit;
        logic [15:0] drift_threshold_ms;
        logic [15:0] data_airtime_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  phase;
        logic        connect_sent;
        logic [15:0] frame_period;
        logic [15:0] master_slot;
        logic [15:0] guard_time;
    } t_link_ctl;

endpackage

@@ hdl/tdmass_in_if.sv @@
// ----------------------------------------------------------------------------
// TDMA slave event channel
// Valid/ready channel carrying one event word.
// ----------------------------------------------------------------------------
interface tdmass_in_if import tdmass_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/tdmass_out_if.sv @@
// ----------------------------------------------------------------------------
// TDMA slave result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface tdmass_out_if import tdmass_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/tdmass_cfg_if.sv @@
// ----------------------------------------------------------------------------
// TDMA slave configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tdmass_cfg_if import tdmass_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/tdmass_slot.sv @@
// ----------------------------------------------------------------------------
// TDMA slave slot position
// Position of a local time inside the current frame, saturated to +-2^32 ms.
// ----------------------------------------------------------------------------
module tdmass_slot import tdmass_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic [TIME_BITS-1:0]     i_time,
    input  logic [TIME_BITS-1:0]     i_offset,
    input  logic [TIME_BITS-1:0]     i_origin,
    output logic signed [SLOT_W-1:0] o_slot
);

    localparam int MAG_W = (TIME_BITS > SLOT_SAT_LOG2 + 1) ? TIME_BITS : SLOT_SAT_LOG2 + 1;
    localparam logic [MAG_W-1:0] SLOT_SAT = MAG_W'(1) << SLOT_SAT_LOG2;

    logic [TIME_BITS-1:0] w_pos;
    logic [TIME_BITS-1:0] w_neg;
    logic [MAG_W-1:0]     w_mag;
    logic [SLOT_W-1:0]    w_sat;

    assign w_pos = i_time + i_offset - i_origin;
    assign w_neg = TIME_BITS'(0) - w_pos;
    assign w_mag = w_pos[TIME_BITS-1] ? MAG_W'(w_neg) : MAG_W'(w_pos);
    // clamp magnitude, then restore sign
    assign w_sat = (w_mag > SLOT_SAT) ? SLOT_W'(SLOT_SAT) : SLOT_W'(w_mag);
    assign o_slot = w_pos[TIME_BITS-1] ? $signed(SLOT_W'(0) - w_sat) : $signed(w_sat);

endmodule

@@ hdl/tdmass_state.sv @@
// ----------------------------------------------------------------------------
// TDMA slave link state
// Link state registers and their update for one event.
// ----------------------------------------------------------------------------
module tdmass_state import tdmass_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_in_item             i_item,
    input  t_cfg                 i_cfg,
    output t_link_ctl            o_ctl,
    output logic [TIME_BITS-1:0] o_offset,
    output logic [TIME_BITS-1:0] o_origin,
    output logic                 o_arrived
);

    function automatic logic [TIME_BITS-1:0] mag_of(input logic [TIME_BITS-1:0] v);
        return v[TIME_BITS-1] ? (TIME_BITS'(0) - v) : v;
    endfunction

    // halve, truncating toward zero
    function automatic logic [TIME_BITS-1:0] half_signed(input logic [TIME_BITS-1:0] v);
        logic [TIME_BITS-1:0] r;
        r = v + TIME_BITS'(v[TIME_BITS-1]);
        return {r[TIME_BITS-1], r[TIME_BITS-1:1]};
    endfunction

    logic [1:0]           r_phase, n_phase;
    logic                 r_cs, n_cs;
    logic [TIME_BITS-1:0] r_offset, n_offset;
    logic [TIME_BITS-1:0] r_srx, n_srx;
    logic [TIME_BITS-1:0] r_stx, n_stx;
    logic [TIME_BITS-1:0] r_origin, n_origin;
    logic [TIME_BITS-1:0] r_trip, n_trip;
    logic [TIME_BITS-1:0] r_ctx, n_ctx;
    logic [15:0]          r_per, n_per;
    logic [15:0]          r_ms, n_ms;
    logic [15:0]          r_gd, n_gd;
    logic [7:0]           r_miss, n_miss;
    logic                 r_sync_seen, n_sync_seen;

    logic [TIME_BITS-1:0]     w_t, w_sent, w_seen;
    logic                     w_from_master;
    logic signed [SLOT_W-1:0] w_slot;
    logic                     w_slot_in_rx;
    logic [REM_W-1:0]         w_tx_rem;
    logic [TIME_BITS-1:0]     w_acc_offset, w_acc_trip;
    logic [TIME_BITS-1:0]     w_sync_offset, w_drift;
    logic                     w_drift_big;
    logic [7:0]               w_miss_up;
    logic                     w_clear;

    assign w_t    = TIME_BITS'(i_item.event_time_ms);
    assign w_sent = TIME_BITS'(i_item.pkt_sent_time);
    assign w_seen = TIME_BITS'(i_item.pkt_connect_seen_time);
    assign w_from_master = (i_item.command == CMD_PKT_RX) &&
                           (i_item.pkt_source == i_cfg.master_node_id);

    tdmass_slot #(.TIME_BITS(TIME_BITS)) u_slot (
        .i_time   (w_t),
        .i_offset (r_offset),
        .i_origin (r_origin),
        .o_slot   (w_slot)
    );

    assign w_slot_in_rx = w_slot <= $signed(SLOT_W'(r_ms));
    assign w_tx_rem = REM_W'(r_per) - REM_W'(r_gd) - REM_W'(w_slot)
                    - REM_W'(i_cfg.data_airtime_ms);

    // offset and trip time from the four handshake timestamps
    assign w_acc_offset = half_signed((r_stx - r_srx) + (w_seen - r_ctx));
    assign w_acc_trip   = half_signed((w_seen - r_stx) - (r_ctx - r_srx));

    assign w_sync_offset = w_sent + r_trip - w_t;
    assign w_drift       = w_sync_offset - r_offset;
    assign w_drift_big   = mag_of(w_drift) > TIME_BITS'(i_cfg.drift_threshold_ms);

    assign w_miss_up = (!r_sync_seen && r_miss != MISS_MAX) ? r_miss + 8'd1 : r_miss;

    always_comb begin
        n_phase     = r_phase;
        n_cs        = r_cs;
        n_offset    = r_offset;
        n_srx       = r_srx;
        n_stx       = r_stx;
        n_origin    = r_origin;
        n_trip      = r_trip;
        n_ctx       = r_ctx;
        n_per       = r_per;
        n_ms        = r_ms;
        n_gd        = r_gd;
        n_miss      = r_miss;
        n_sync_seen = r_sync_seen;
        w_clear     = 1'b0;
        if (i_en) begin
            unique case (r_phase)
                PH_DISC: begin
                    if (w_from_master && i_item.pkt_kind == KIND_SYNC) begin
                        n_srx   = w_t;
                        n_stx   = w_sent;
                        n_per   = i_item.pkt_period_ms;
                        n_ms    = i_item.pkt_master_slot_ms;
                        n_gd    = i_item.pkt_guard_ms;
                        n_phase = PH_CONNECTING;
                    end else begin
                        w_clear = 1'b1;
                    end
                end
                PH_CONNECTING: begin
                    if (!r_cs) begin
                        if (i_item.command == CMD_TX_DONE) begin
                            n_ctx = w_t;
                            n_cs  = 1'b1;
                        end else if (i_item.command == CMD_TX_FAIL) begin
                            w_clear = 1'b1;
                        end
                    end else if (i_item.command == CMD_PKT_RX) begin
                        if (w_from_master && i_item.pkt_kind == KIND_ACCEPT) begin
                            n_offset = w_acc_offset;
                            n_trip   = w_acc_trip;
                            n_origin = r_stx;
                            n_cs     = 1'b0;
                            n_phase  = PH_RX;
                        end else begin
                            w_clear = 1'b1;
                        end
                    end else if (i_item.command == CMD_RX_TIMEOUT) begin
                        w_clear = 1'b1;
                    end
                end
                PH_TX: begin
                    if (w_slot_in_rx) begin
                        n_sync_seen = 1'b0;
                        n_phase     = PH_RX;
                    end else if (w_tx_rem[REM_W-1]) begin
                        // data no longer fits: expect the next sync one period on
                        n_sync_seen = 1'b0;
                        n_origin    = r_origin + TIME_BITS'(r_per);
                        n_phase     = PH_RX;
                    end
                end
                PH_RX: begin
                    if (i_item.command == CMD_PKT_RX) begin
                        if (w_from_master && i_item.pkt_kind == KIND_SYNC) begin
                            n_srx       = w_t;
                            n_stx       = w_sent;
                            n_origin    = w_sent;
                            n_sync_seen = 1'b1;
                            n_miss      = 8'd0;
                            if (!i_item.pkt_linked) begin
                                w_clear = 1'b1;
                            end else begin
                                if (w_drift_big) begin
                                    n_offset = w_sync_offset;
                                end
                                n_per = i_item.pkt_period_ms;
                                n_ms  = i_item.pkt_master_slot_ms;
                                n_gd  = i_item.pkt_guard_ms;
                            end
                        end
                    end else if (i_item.command == CMD_RX_TIMEOUT || !w_slot_in_rx) begin
                        // window over: count a miss if no sync came, drop the link past the limit
                        n_miss = w_miss_up;
                        if (w_miss_up > i_cfg.miss_limit) begin
                            w_clear = 1'b1;
                        end else begin
                            n_phase = PH_TX;
                        end
                    end
                end
                default: begin
                    w_clear = 1'b1;
                end
            endcase
        end
        if (w_clear) begin
            n_phase     = PH_DISC;
            n_cs        = 1'b0;
            n_offset    = '0;
            n_srx       = '0;
            n_stx       = '0;
            n_origin    = '0;
            n_trip      = '0;
            n_ctx       = '0;
            n_per       = '0;
            n_ms        = '0;
            n_gd        = '0;
            n_miss      = '0;
            n_sync_seen = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DISC;
            r_cs        <= 1'b0;
            r_offset    <= '0;
            r_srx       <= '0;
            r_stx       <= '0;
            r_origin    <= '0;
            r_trip      <= '0;
            r_ctx       <= '0;
            r_per       <= '0;
            r_ms        <= '0;
            r_gd        <= '0;
            r_miss      <= '0;
            r_sync_seen <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_cs        <= n_cs;
            r_offset    <= n_offset;
            r_srx       <= n_srx;
            r_stx       <= n_stx;
            r_origin    <= n_origin;
            r_trip      <= n_trip;
            r_ctx       <= n_ctx;
            r_per       <= n_per;
            r_ms        <= n_ms;
            r_gd        <= n_gd;
            r_miss      <= n_miss;
            r_sync_seen <= n_sync_seen;
        end
    end

    assign o_arrived = (r_phase == PH_RX) && w_from_master &&
                       (i_item.pkt_kind == KIND_COMMAND);

    assign o_ctl.phase        = r_phase;
    assign o_ctl.connect_sent = r_cs;
    assign o_ctl.frame_period = r_per;
    assign o_ctl.master_slot  = r_ms;
    assign o_ctl.guard_time   = r_gd;
    assign o_offset           = r_offset;
    assign o_origin           = r_origin;

endmodule

@@ hdl/tdmass_action.sv @@
// ----------------------------------------------------------------------------
// TDMA slave radio action
// Next radio action, its budget and the reported offset from the link state.
// ----------------------------------------------------------------------------
module tdmass_action import tdmass_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic [TIME_BITS-1:0] i_time,
    input  logic                 i_arrived,
    input  t_link_ctl            i_ctl,
    input  logic [TIME_BITS-1:0] i_offset,
    input  logic [TIME_BITS-1:0] i_origin,
    input  logic [15:0]          i_airtime_ms,
    output t_out_item            o_item
);

    logic signed [SLOT_W-1:0] w_slot;
    logic [REM_W-1:0]         w_tx_rem;
    logic [REM_W-1:0]         w_rx_rem;
    logic                     w_past_rx;

    tdmass_slot #(.TIME_BITS(TIME_BITS)) u_slot (
        .i_time   (i_time),
        .i_offset (i_offset),
        .i_origin (i_origin),
        .o_slot   (w_slot)
    );

    assign w_past_rx = w_slot > $signed(SLOT_W'(i_ctl.master_slot));
    assign w_tx_rem  = REM_W'(i_ctl.frame_period) - REM_W'(i_ctl.guard_time)
                     - REM_W'(w_slot) - REM_W'(i_airtime_ms);
    assign w_rx_rem  = REM_W'(i_ctl.master_slot) - REM_W'(w_slot);

    always_comb begin
        o_item.link_state        = i_ctl.phase;
        o_item.command_arrived   = i_arrived;
        o_item.clock_offset_ms   = FIELD_TIME_W'($signed(i_offset));
        o_item.radio_action      = ACT_NONE;
        o_item.action_timeout_ms = '0;
        unique case (i_ctl.phase)
            PH_DISC: begin
                o_item.radio_action      = ACT_LISTEN;
                o_item.action_timeout_ms = IDLE_LISTEN_MS;
            end
            PH_CONNECTING: begin
                o_item.radio_action      = i_ctl.connect_sent ? ACT_LISTEN : ACT_SEND_CONNECT;
                o_item.action_timeout_ms = {1'b0, i_ctl.frame_period[15:1]};
            end
            PH_TX: begin
                if (w_past_rx && !w_tx_rem[REM_W-1]) begin
                    o_item.radio_action      = ACT_SEND_DATA;
                    o_item.action_timeout_ms = w_tx_rem[15:0];
                end
            end
            PH_RX: begin
                // clamp the listen budget to 0..65535
                o_item.radio_action = ACT_LISTEN;
                if (w_rx_rem[REM_W-1]) begin
                    o_item.action_timeout_ms = '0;
                end else if (w_rx_rem[REM_W-2:16] != '0) begin
                    o_item.action_timeout_ms = BUDGET_MAX;
                end else begin
                    o_item.action_timeout_ms = w_rx_rem[15:0];
                end
            end
            default: begin
                o_item.radio_action = ACT_NONE;
            end
        endcase
    end

endmodule

@@ hdl/tdma_slave_sync_slot_controller.sv @@
// ----------------------------------------------------------------------------
// TDMA slave sync slot controller
// Slave side of a two-node time-slotted radio link: handshake, round-trip clock
// offset estimate, slot scheduling, drift correction and missed-sync supervision.
// ----------------------------------------------------------------------------
// Every event word yields exactly one result word. The block takes a new
// event in every cycle when the output is not stalled and passes it
// through an input register, a state stage that updates the link
// registers, and an action stage that turns the updated state and the
// event time into the result register. Throughput is one word per cycle,
// set by the link state update. A stall on the result side backs
// up into the input channel one stage at a time. Configuration
// registers are written through their own channel, which is always ready;
// write them only while no event is in flight. Time arithmetic is carried out
// at TIME_BITS bits and wraps; the time fields on the ports stay 48 bits and
// the offset is sign extended or truncated to 48 bits on output.
// ----------------------------------------------------------------------------
module tdma_slave_sync_slot_controller import tdmass_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tdmass_cfg_if.sink   i_cfg,
    tdmass_in_if.sink    i_in,
    tdmass_out_if.source o_out
);

    // Configuration registers
    t_cfg r_cfg;

    // Pipeline registers
    logic                 r_in_valid;
    t_in_item             r_in;
    logic                 r_mid_valid;
    logic [TIME_BITS-1:0] r_mid_time;
    logic                 r_mid_arrived;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 w_in_take;
    logic                 w_adv_in;
    logic                 w_adv_out;
    logic                 w_arrived;
    t_link_ctl            w_ctl;
    logic [TIME_BITS-1:0] w_offset;
    logic [TIME_BITS-1:0] w_origin;
    t_out_item            w_result;

    // ---- configuration port: always ready, decode register index
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.master_node_id     <= '0;
            r_cfg.miss_limit         <= MISS_LIMIT_RST;
            r_cfg.drift_threshold_ms <= DRIFT_THR_RST;
            r_cfg.data_airtime_ms    <= AIRTIME_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MASTER_NODE_ID: r_cfg.master_node_id     <= i_cfg.data[7:0];
                REG_MISS_LIMIT:     r_cfg.miss_limit         <= i_cfg.data[7:0];
                REG_DRIFT_THR:      r_cfg.drift_threshold_ms <= i_cfg.data;
                REG_AIRTIME:        r_cfg.data_airtime_ms    <= i_cfg.data;
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // ---- handshake: each stage advances when the one after it frees up.
    // The state stage may only commit while the action stage either is
    // empty or hands its word on in the same cycle, so the action stage
    // always sees the state left by its own event.
    assign w_adv_out  = r_mid_valid && (!r_out_valid || o_out.ready);
    assign w_adv_in   = r_in_valid && (!r_mid_valid || w_adv_out);
    assign i_in.ready = !r_in_valid || w_adv_in;
    assign w_in_take  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // hold each valid until its word moves on
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv_in) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv_in) begin
                r_mid_valid <= 1'b1;
            end else if (w_adv_out) begin
                r_mid_valid <= 1'b0;
            end
            if (w_adv_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in.data;
        end
        if (w_adv_in) begin
            r_mid_time    <= TIME_BITS'(r_in.event_time_ms);
            r_mid_arrived <= w_arrived;
        end
        if (w_adv_out) begin
            r_out <= w_result;
        end
    end

    // ---- state stage: link state update for the event in the input register
    tdmass_state #(.TIME_BITS(TIME_BITS)) u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_adv_in),
        .i_item    (r_in),
        .i_cfg     (r_cfg),
        .o_ctl     (w_ctl),
        .o_offset  (w_offset),
        .o_origin  (w_origin),
        .o_arrived (w_arrived)
    );

    // ---- action stage: result word from the updated state
    tdmass_action #(.TIME_BITS(TIME_BITS)) u_action (
        .i_time       (r_mid_time),
        .i_arrived    (r_mid_arrived),
        .i_ctl        (w_ctl),
        .i_offset     (w_offset),
        .i_origin     (w_origin),
        .i_airtime_ms (r_cfg.data_airtime_ms),
        .o_item       (w_result)
    );

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

@@ verif/tdmass_checker.sv @@
// ----------------------------------------------------------------------------
// TDMA slave slot controller checker
// Watches the event, result and register channels, predicts the link report
// for every accepted event word and compares it with the delivered result word.
// ----------------------------------------------------------------------------
module tdmass_checker import tdmass_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tdmass_cfg_if i_cfg,
    tdmass_in_if  i_evt,
    tdmass_out_if i_res,
    output int    o_mismatch_count,
    output int    o_reports_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TW = FIELD_TIME_W;
    typedef logic [TW-1:0] ms_t;
    localparam ms_t SLOT_LIM = ms_t'(64'd1 << SLOT_SAT_LOG2);

    t_cfg       regs;
    logic [1:0] phase;
    ms_t        offs, sync_rx, sync_tx, origin, trip, connect_tx;
    logic [15:0] period, mslot, guard;
    logic [7:0] misses;
    logic       synced, connect_out;
    t_out_item  reports_due[$];

    function automatic ms_t mag(input ms_t v);
        return v[TW-1] ? ~v + 1'b1 : v;
    endfunction

    // Halve a two's complement time, truncating toward zero
    function automatic ms_t halve(input ms_t v);
        ms_t m;
        m = mag(v) >> 1;
        return v[TW-1] ? ~m + 1'b1 : m;
    endfunction

    // Position in the current frame, saturated to +-2^32 ms
    function automatic longint slot_pos(input ms_t t);
        ms_t    v, m;
        longint s;
        v = t + offs - origin;
        m = mag(v);
        s = (m > SLOT_LIM) ? longint'(SLOT_LIM) : longint'(m);
        return v[TW-1] ? -s : s;
    endfunction

    task automatic drop_link();
        phase       = PH_DISC;
        offs        = '0;
        sync_rx     = '0;
        sync_tx     = '0;
        origin      = '0;
        trip        = '0;
        connect_tx  = '0;
        period      = '0;
        mslot       = '0;
        guard       = '0;
        misses      = '0;
        synced      = 1'b0;
        connect_out = 1'b0;
    endtask

    task automatic close_window();
        if (!synced && misses < MISS_MAX) misses++;
        if (misses > regs.miss_limit) drop_link();
        else phase = PH_TX;
    endtask

    task automatic predict_link_report(input t_in_item ev, output t_out_item rep);
        logic   from_master;
        longint s, rem;
        ms_t    drift;
        from_master = (ev.command == CMD_PKT_RX) && (ev.pkt_source == regs.master_node_id);
        rep = '0;
        case (phase)
            PH_DISC: begin
                drop_link();
                if (from_master && ev.pkt_kind == KIND_SYNC) begin
                    sync_rx = ev.event_time_ms;
                    sync_tx = ev.pkt_sent_time;
                    period  = ev.pkt_period_ms;
                    mslot   = ev.pkt_master_slot_ms;
                    guard   = ev.pkt_guard_ms;
                    phase   = PH_CONNECTING;
                end
            end
            PH_CONNECTING: begin
                if (!connect_out) begin
                    if (ev.command == CMD_TX_DONE) begin
                        connect_tx  = ev.event_time_ms;
                        connect_out = 1'b1;
                    end else if (ev.command == CMD_TX_FAIL) begin
                        drop_link();
                    end
                end else if (ev.command == CMD_PKT_RX) begin
                    if (from_master && ev.pkt_kind == KIND_ACCEPT) begin
                        offs = halve((sync_tx - sync_rx) + (ev.pkt_connect_seen_time - connect_tx));
                        trip = halve((ev.pkt_connect_seen_time - sync_tx) - (connect_tx - sync_rx));
                        origin      = sync_tx;
                        connect_out = 1'b0;
                        phase       = PH_RX;
                    end else begin
                        drop_link();
                    end
                end else if (ev.command == CMD_RX_TIMEOUT) begin
                    drop_link();
                end
            end
            PH_TX: begin
                s   = slot_pos(ev.event_time_ms);
                rem = longint'(period) - longint'(guard) - s;
                if (s <= longint'(mslot)) begin
                    synced = 1'b0;
                    phase  = PH_RX;
                end else if (rem - longint'(regs.data_airtime_ms) < 0) begin
                    synced = 1'b0;
                    origin = origin + ms_t'(period);
                    phase  = PH_RX;
                end
            end
            default: begin
                if (ev.command == CMD_PKT_RX) begin
                    if (from_master && ev.pkt_kind == KIND_SYNC) begin
                        sync_rx = ev.event_time_ms;
                        sync_tx = ev.pkt_sent_time;
                        origin  = ev.pkt_sent_time;
                        synced  = 1'b1;
                        misses  = '0;
                        if (!ev.pkt_linked) begin
                            drop_link();
                        end else begin
                            drift = ev.pkt_sent_time + trip - ev.event_time_ms - offs;
                            if (mag(drift) > ms_t'(regs.drift_threshold_ms)) offs = offs + drift;
                            period = ev.pkt_period_ms;
                            mslot  = ev.pkt_master_slot_ms;
                            guard  = ev.pkt_guard_ms;
                        end
                    end else if (from_master && ev.pkt_kind == KIND_COMMAND) begin
                        rep.command_arrived = 1'b1;
                    end
                end else begin
                    s = slot_pos(ev.event_time_ms);
                    if (ev.command == CMD_RX_TIMEOUT || longint'(mslot) - s < 0) close_window();
                end
            end
        endcase

        // Report the action that the updated state calls for
        rep.radio_action      = ACT_NONE;
        rep.action_timeout_ms = '0;
        case (phase)
            PH_DISC: begin
                rep.radio_action      = ACT_LISTEN;
                rep.action_timeout_ms = IDLE_LISTEN_MS;
            end
            PH_CONNECTING: begin
                rep.radio_action      = connect_out ? ACT_LISTEN : ACT_SEND_CONNECT;
                rep.action_timeout_ms = period >> 1;
            end
            PH_TX: begin
                s   = slot_pos(ev.event_time_ms);
                rem = longint'(period) - longint'(guard) - s - longint'(regs.data_airtime_ms);
                if (s > longint'(mslot) && rem >= 0) begin
                    rep.radio_action      = ACT_SEND_DATA;
                    rep.action_timeout_ms = rem[15:0];
                end
            end
            default: begin
                s   = slot_pos(ev.event_time_ms);
                rem = longint'(mslot) - s;
                if (rem < 0) rem = 0;
                if (rem > longint'(BUDGET_MAX)) rem = longint'(BUDGET_MAX);
                rep.radio_action      = ACT_LISTEN;
                rep.action_timeout_ms = rem[15:0];
            end
        endcase
        rep.link_state      = phase;
        rep.clock_offset_ms = offs;
    endtask

    function automatic int field_differs(input string name, input ms_t want, input ms_t got);
        if (got === want) return 0;
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_out_item rep, got;
        if (!i_rst_n) begin
            regs.master_node_id     = '0;
            regs.miss_limit         = MISS_LIMIT_RST;
            regs.drift_threshold_ms = DRIFT_THR_RST;
            regs.data_airtime_ms    = AIRTIME_RST;
            drop_link();
            reports_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_MASTER_NODE_ID: regs.master_node_id     = i_cfg.data[7:0];
                    REG_MISS_LIMIT:     regs.miss_limit         = i_cfg.data[7:0];
                    REG_DRIFT_THR:      regs.drift_threshold_ms = i_cfg.data;
                    REG_AIRTIME:        regs.data_airtime_ms    = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_evt.valid && i_evt.ready) begin
                predict_link_report(i_evt.data, rep);
                reports_due.push_back(rep);
            end
            if (i_res.valid && i_res.ready) begin
                got = i_res.data;
                if (reports_due.size() == 0) begin
                    $display("%0t ns: unexpected result word, expected none, got state %0d action %0d timeout %0d cmd %0b offset %0h",
                             $time, got.link_state, got.radio_action, got.action_timeout_ms,
                             got.command_arrived, got.clock_offset_ms);
                    o_mismatch_count++;
                end else begin
                    rep = reports_due.pop_front();
                    o_mismatch_count += field_differs("link_state", ms_t'(rep.link_state),
                                                      ms_t'(got.link_state));
                    o_mismatch_count += field_differs("radio_action", ms_t'(rep.radio_action),
                                                      ms_t'(got.radio_action));
                    o_mismatch_count += field_differs("action_timeout_ms",
                                                      ms_t'(rep.action_timeout_ms),
                                                      ms_t'(got.action_timeout_ms));
                    o_mismatch_count += field_differs("command_arrived",
                                                      ms_t'(rep.command_arrived),
                                                      ms_t'(got.command_arrived));
                    o_mismatch_count += field_differs("clock_offset_ms",
                                                      ms_t'(rep.clock_offset_ms),
                                                      ms_t'(got.clock_offset_ms));
                end
            end
        end
        o_reports_due = reports_due.size();
    end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// TDMA slave slot controller testbench
// Drives directed and random event words, including full link handshakes and
// connected frames, through the slot controller under random source bursts and
// sink stalls, across several register settings; a checker instance beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench import tdmass_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [FIELD_TIME_W-1:0] ms_t;

    // Codes not named in the package
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_LAST     = 3'd7;
    localparam logic [2:0] KIND_CONNECT = 3'd1;
    localparam logic [2:0] KIND_DATA    = 3'd4;
    localparam logic [2:0] KIND_LAST    = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = REG_AIRTIME + 1'b1;
    localparam ms_t TIME_MAX = '1;

    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 75;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   reports_due;

    tdmass_in_if  evt_ch ();
    tdmass_out_if res_ch ();
    tdmass_cfg_if cfg_ch ();

    tdma_slave_sync_slot_controller DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch.sink),
        .i_in    (evt_ch.sink),
        .o_out   (res_ch.source)
    );

    tdmass_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg            (cfg_ch),
        .i_evt            (evt_ch),
        .i_res            (res_ch),
        .o_mismatch_count (mismatches),
        .o_reports_due    (reports_due)
    );

    // Stimulus state: local time, master clock skew and current frame geometry
    ms_t         now_ms;
    ms_t         master_skew;
    logic [15:0] per, win, guard;
    logic [7:0]  master_id;
    int          burst_left;
    int          items_sent;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the handshakes hang
    initial begin
        #10ms;
        $display("testbench NOT OK");
        $finish;
    end

    // Result sink: switch between stall patterns in stretches of random length
    initial begin
        int mode, len;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(4, 40);
            for (int k = 0; k < len; k++) begin
                @(negedge clk);
                case (mode)
                    0: res_ch.ready = 1'b1;
                    1: res_ch.ready = 1'($urandom_range(0, 1));
                    2: res_ch.ready = ($urandom_range(0, 6) != 0);
                    default: res_ch.ready = (k >= len / 2);   // hold off, then drain
                endcase
            end
        end
    end

    function automatic ms_t rand48();
        return ms_t'({$urandom(), $urandom()});
    endfunction

    // Fully random event word: covers every bit of every field
    function automatic t_in_item noise_item();
        t_in_item it;
        it.command               = 3'($urandom_range(0, 7));
        it.event_time_ms         = rand48();
        it.pkt_kind              = 3'($urandom_range(0, 7));
        it.pkt_source            = 8'($urandom_range(0, 255));
        it.pkt_sent_time         = rand48();
        it.pkt_period_ms         = 16'($urandom);
        it.pkt_master_slot_ms    = 16'($urandom);
        it.pkt_guard_ms          = 16'($urandom);
        it.pkt_linked            = 1'($urandom_range(0, 1));
        it.pkt_connect_seen_time = rand48();
        return it;
    endfunction

    // Event at the current local time; fields the command ignores stay random
    function automatic t_in_item make_event(input logic [2:0] cmd);
        t_in_item it;
        it               = noise_item();
        it.command       = cmd;
        it.event_time_ms = now_ms;
        return it;
    endfunction

    // Present one word and hold it until accepted, then maybe open a gap
    task automatic send_event(input t_in_item it);
        int gap;
        @(negedge clk);
        evt_ch.data  = it;
        evt_ch.valid = 1'b1;
        do @(posedge clk); while (!evt_ch.ready);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, 8);
            if (gap > 0) begin
                @(negedge clk);
                evt_ch.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // Directed word with every field spelled out
    task automatic send_fields(input logic [2:0] cmd, input ms_t t, input logic [2:0] kind,
                               input logic [7:0] src, input ms_t sent, input logic [15:0] p,
                               input logic [15:0] ms, input logic [15:0] gd,
                               input logic linked, input ms_t seen);
        t_in_item it;
        it.command               = cmd;
        it.event_time_ms         = t;
        it.pkt_kind              = kind;
        it.pkt_source            = src;
        it.pkt_sent_time         = sent;
        it.pkt_period_ms         = p;
        it.pkt_master_slot_ms    = ms;
        it.pkt_guard_ms          = gd;
        it.pkt_linked            = linked;
        it.pkt_connect_seen_time = seen;
        send_event(it);
    endtask

    // Drop valid and hold until every result word has come back
    task automatic settle();
        @(negedge clk);
        evt_ch.valid = 1'b0;
        while (reports_due != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic configure(input logic [7:0] mid, input logic [7:0] miss,
                             input logic [15:0] thr, input logic [15:0] air);
        settle();
        write_reg(REG_MASTER_NODE_ID, 16'(mid));
        write_reg(REG_MISS_LIMIT, 16'(miss));
        write_reg(REG_DRIFT_THR, thr);
        write_reg(REG_AIRTIME, air);
        master_id = mid;
    endtask

    // Reset defaults: master id 0, miss limit 3, threshold 10, airtime 100
    task automatic run_directed();
        // Extremes of every field while disconnected
        send_fields(CMD_TICK, '0, KIND_SYNC, '0, '0, '0, '0, '0, 1'b0, '0);
        send_fields(CMD_LAST, TIME_MAX, KIND_LAST, 8'hFF, TIME_MAX, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 1'b1, TIME_MAX);
        send_fields(CMD_PKT_RX, 10, KIND_CONNECT, '0, '0, '0, '0, '0, 1'b1, '0);
        send_fields(CMD_RX_TIMEOUT, 20, KIND_SYNC, '0, '0, '0, '0, '0, 1'b1, '0);
        // Sync from a stranger does not start the handshake
        send_fields(CMD_PKT_RX, 50, KIND_SYNC, 8'd1, 100, 1000, 200, 50, 1'b1, '0);
        // Handshake aborted by a failed connect transmission
        send_fields(CMD_PKT_RX, 100, KIND_SYNC, '0, 48'hFFFF_FFFF_FF00, 1000, 200, 50,
                    1'b0, '0);
        send_fields(CMD_TICK, 110, KIND_SYNC, '0, '0, '0, '0, '0, 1'b0, '0);
        send_fields(CMD_RX_TIMEOUT, 120, KIND_SYNC, '0, '0, '0, '0, '0, 1'b0, '0);
        send_fields(CMD_TX_FAIL, 130, KIND_SYNC, '0, '0, '0, '0, '0, 1'b0, '0);
        // Handshake with wrapping timestamps and maximal window values
        send_fields(CMD_PKT_RX, 1000, KIND_SYNC, '0, TIME_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    1'b1, '0);
        send_fields(CMD_TX_DONE, 1010, KIND_SYNC, '0, '0, '0, '0, '0, 1'b0, '0);
        send_fields(CMD_PKT_RX, 1030, KIND_ACCEPT, '0, '0, '0, '0, '0, 1'b0, 48'd5);
        // Command from master flagged, command from a stranger ignored
        send_fields(CMD_PKT_RX, 1040, KIND_COMMAND, '0, '0, '0, '0, '0, 1'b0, '0);
        send_fields(CMD_PKT_RX, 1050, KIND_COMMAND, 8'hFF, '0, '0, '0, '0, 1'b0, '0);
        // Sync saying the link is down disconnects
        send_fields(CMD_PKT_RX, 1060, KIND_SYNC, '0, 48'd5, 1000, 200, 100, 1'b0, '0);
        // Clean handshake, then a data slot, window roll-over and missed syncs
        send_fields(CMD_PKT_RX, 5000, KIND_SYNC, '0, 7000, 1000, 200, 100, 1'b1, '0);
        send_fields(CMD_TX_DONE, 5002, KIND_SYNC, '0, '0, '0, '0, '0, 1'b0, '0);
        send_fields(CMD_PKT_RX, 5010, KIND_ACCEPT, '0, '0, '0, '0, '0, 1'b0, 7004);
        send_fields(CMD_TICK, 5300, KIND_DATA, '0, '0, '0, '0, '0, 1'b0, '0);
        send_fields(CMD_TICK, 5800, KIND_DATA, '0, '0, '0, '0, '0, 1'b0, '0);
        send_fields(CMD_RX_TIMEOUT, 5850, KIND_DATA, '0, '0, '0, '0, '0, 1'b0, '0);
        send_fields(CMD_TICK, 5860, KIND_DATA, '0, '0, '0, '0, '0, 1'b0, '0);
        send_fields(CMD_RX_TIMEOUT, 5870, KIND_DATA, '0, '0, '0, '0, '0, 1'b0, '0);
        send_fields(CMD_TICK, 5880, KIND_DATA, '0, '0, '0, '0, '0, 1'b0, '0);
        send_fields(CMD_RX_TIMEOUT, 5890, KIND_DATA, '0, '0, '0, '0, '0, 1'b0, '0);
    endtask

    // One link lifetime: sync, connect, accept, then a run of connected events.
    // A few sessions break the handshake on purpose.
    task automatic run_link_session();
        t_in_item it;
        int       r;
        if ($urandom_range(0, 7) == 0) begin
            per   = 16'($urandom);
            win   = 16'($urandom);
            guard = 16'($urandom);
        end else begin
            per   = 16'($urandom_range(300, 5000));
            win   = 16'($urandom_range(0, per / 3));
            guard = 16'($urandom_range(0, per / 10));
        end
        master_skew = ($urandom_range(0, 1) == 0) ? rand48()
                                                  : ms_t'($urandom_range(0, 10000)) - 5000;

        // A little noise while disconnected
        repeat ($urandom_range(0, 2)) send_event(noise_item());

        now_ms += ms_t'($urandom_range(1, 1000));
        it = make_event(CMD_PKT_RX);
        it.pkt_kind           = KIND_SYNC;
        it.pkt_source         = master_id;
        it.pkt_sent_time      = now_ms + master_skew - ms_t'($urandom_range(0, 20));
        it.pkt_period_ms      = per;
        it.pkt_master_slot_ms = win;
        it.pkt_guard_ms       = guard;
        send_event(it);

        if ($urandom_range(0, 9) == 0) begin
            send_event(make_event(CMD_TX_FAIL));
            return;
        end
        if ($urandom_range(0, 3) == 0)
            send_event(make_event(($urandom_range(0, 1) == 0) ? CMD_TICK : CMD_RX_TIMEOUT));
        now_ms += ms_t'($urandom_range(1, 30));
        send_event(make_event(CMD_TX_DONE));
        now_ms += ms_t'($urandom_range(1, 30));

        if ($urandom_range(0, 9) == 0) begin
            // Broken handshake: anything but an accept from the master
            it = make_event(($urandom_range(0, 1) == 0) ? CMD_PKT_RX : CMD_RX_TIMEOUT);
            if (it.pkt_kind == KIND_ACCEPT) it.pkt_kind = KIND_COMMAND;
            send_event(it);
            return;
        end
        it = make_event(CMD_PKT_RX);
        it.pkt_kind              = KIND_ACCEPT;
        it.pkt_source            = master_id;
        it.pkt_connect_seen_time = now_ms + master_skew - ms_t'($urandom_range(0, 20));
        send_event(it);

        repeat ($urandom_range(10, 60)) begin
            // Advance mostly within the frame, now and then far ahead
            if ($urandom_range(0, 29) == 0) now_ms += rand48();
            else now_ms += ms_t'($urandom_range(0, per / 3 + 1));
            r = $urandom_range(0, 99);
            if (r < 45) begin
                it = make_event(($urandom_range(0, 7) == 0)
                                ? CMD_TX_FAIL + 3'($urandom_range(1, 3)) : CMD_TICK);
            end else if (r < 60) begin
                it = make_event(CMD_PKT_RX);
                it.pkt_kind      = KIND_SYNC;
                it.pkt_source    = master_id;
                it.pkt_sent_time = now_ms + master_skew + ms_t'($urandom_range(0, 80)) - 40;
                if ($urandom_range(0, 9) == 0)
                    it.pkt_sent_time += ms_t'($urandom_range(0, 4000)) - 2000;
                it.pkt_linked = ($urandom_range(0, 19) != 0);
                if ($urandom_range(0, 4) != 0) begin
                    it.pkt_period_ms      = per;
                    it.pkt_master_slot_ms = win;
                    it.pkt_guard_ms       = guard;
                end
            end else if (r < 70) begin
                it = make_event(CMD_RX_TIMEOUT);
            end else if (r < 78) begin
                it = make_event(CMD_PKT_RX);
                it.pkt_kind   = KIND_COMMAND;
                it.pkt_source = master_id;
            end else if (r < 84) begin
                it = make_event(CMD_PKT_RX);
                it.pkt_source = master_id;
                if (it.pkt_kind == KIND_SYNC || it.pkt_kind == KIND_COMMAND)
                    it.pkt_kind = KIND_DATA;
            end else if (r < 90) begin
                it = make_event(CMD_PKT_RX);
                it.pkt_source = master_id + 8'($urandom_range(1, 255));
            end else if (r < 95) begin
                it = make_event(($urandom_range(0, 1) == 0) ? CMD_TX_DONE : CMD_TX_FAIL);
            end else begin
                it = noise_item();
            end
            // Now and then let the pipeline drain completely before going on
            if ($urandom_range(0, 59) == 0) settle();
            send_event(it);
        end
    endtask

    initial begin
        int start;
        rst_n        = 1'b0;
        evt_ch.valid = 1'b0;
        evt_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        now_ms       = '0;
        master_skew  = '0;
        per          = '0;
        win          = '0;
        guard        = '0;
        master_id    = '0;
        burst_left   = 1;
        items_sent   = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();

        // Random phases, each under its own register setting; extremes first
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: configure(8'hFF, 8'd0, 16'd0, 16'd0);
                1: configure(8'd0, 8'hFF, 16'hFFFF, 16'hFFFF);
                2: configure(8'd17, 8'd1, DRIFT_THR_RST, AIRTIME_RST);
                3: configure(8'd0, 8'd0, 16'hFFFF, 16'd0);
                default: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 6)),
                                   16'($urandom_range(0, 200)),
                                   16'($urandom_range(0, 400)));
            endcase
            // A write to an unmapped index must change nothing
            if (ph == 0) write_reg(REG_UNMAPPED, 16'($urandom));
            start = items_sent;
            while (items_sent - start < ITEMS_PER_PHASE) run_link_session();
        end

        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && reports_due == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
